>>> hw/rtl/bcr_pkg.sv
// Shared types and codes for the button click recognizer.
package bcr_pkg;

    typedef struct packed {
        logic        action;
        logic [1:0]  button;
        logic [3:0]  levels;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [1:0] event_button;
        logic       any_held;
        logic       last;
    } t_out_item;

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [2:0] EV_RAW_DOWN     = 3'd0;
    localparam logic [2:0] EV_CLICK        = 3'd1;
    localparam logic [2:0] EV_LONG         = 3'd2;
    localparam logic [2:0] EV_LONG_RELEASE = 3'd3;
    localparam logic [2:0] EV_RAW_UP       = 3'd4;
    localparam logic [2:0] EV_TICK_DONE    = 3'd5;

    localparam logic [1:0] MODE_RELEASED  = 2'd0;
    localparam logic [1:0] MODE_PRESSED   = 2'd1;
    localparam logic [1:0] MODE_REPEATING = 2'd2;
    localparam logic [1:0] MODE_LONG      = 2'd3;

    localparam logic [2:0] CFG_RAW_DOWN_MASK     = 3'd0;
    localparam logic [2:0] CFG_RAW_UP_MASK       = 3'd1;
    localparam logic [2:0] CFG_CLICK_MASK        = 3'd2;
    localparam logic [2:0] CFG_LONG_MASK         = 3'd3;
    localparam logic [2:0] CFG_LONG_RELEASE_MASK = 3'd4;
    localparam logic [2:0] CFG_REPEAT_INTERVALS  = 3'd5;
    localparam logic [2:0] CFG_LONG_DELAYS       = 3'd6;

endpackage

>>> hw/rtl/bcr_time_cmp.sv
// Shared elapsed-time comparator: wrapping elapsed milliseconds against a 16-bit limit.
module bcr_time_cmp (
    input  logic [31:0] i_now,
    input  logic [31:0] i_stamp,
    input  logic [15:0] i_limit,
    output logic        o_gt,
    output logic        o_lt
);

    logic [31:0] elapsed;
    logic [31:0] limit_ext;

    assign elapsed   = i_now - i_stamp;
    assign limit_ext = {16'd0, i_limit};
    assign o_gt      = elapsed > limit_ext;
    assign o_lt      = elapsed < limit_ext;

endmodule

>>> hw/rtl/button_click_recognizer_unit.sv
// Top level of the button click recognizer: sequencer, per-button state and result register.
//
// The block takes one transaction at a time and stalls its input until every result
// of that transaction has been produced. A press is a single step; a release is a
// compare step followed by one step per result; a tick makes one repeat check and
// one long check per held button and a single step for a button that is not held,
// then the summary. Output stall while a result waits holds the sequencer in its
// step. The sequencer walks the buttons one check at a time through a single shared
// elapsed-time comparator.
module button_click_recognizer_unit #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bcr_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bcr_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    localparam int         BW       = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam logic [1:0] LAST_BTN = 2'(BUTTON_COUNT - 1);
    localparam logic [2:0] BTN_LIM  = 3'(BUTTON_COUNT);
    localparam logic [3:0] LVL_MASK = 4'((1 << BUTTON_COUNT) - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PRESS    = 3'd1;
    localparam logic [2:0] S_REL_CMP  = 3'd2;
    localparam logic [2:0] S_REL_EMIT = 3'd3;
    localparam logic [2:0] S_REP      = 3'd4;
    localparam logic [2:0] S_LONG     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam int F_CLICK = 0;
    localparam int F_LREL  = 1;
    localparam int F_RAWUP = 2;

    logic [3:0]  r_rd_mask, r_ru_mask, r_click_mask, r_long_mask, r_lrel_mask;
    logic [63:0] r_rep_int, r_long_dly;

    logic [31:0] r_press_stamp [BUTTON_COUNT];
    logic [31:0] r_rep_stamp   [BUTTON_COUNT];
    logic        r_long_armed  [BUTTON_COUNT];
    logic        r_rep_armed   [BUTTON_COUNT];
    logic [1:0]  r_mode        [BUTTON_COUNT];
    logic [31:0] n_press_stamp [BUTTON_COUNT];
    logic [31:0] n_rep_stamp   [BUTTON_COUNT];
    logic        n_long_armed  [BUTTON_COUNT];
    logic        n_rep_armed   [BUTTON_COUNT];
    logic [1:0]  n_mode        [BUTTON_COUNT];

    logic [2:0]         r_state, n_state;
    bcr_pkg::t_in_item  r_item, n_item;
    logic [1:0]         r_btn, n_btn;
    logic [2:0]         r_flags, n_flags;
    logic               r_out_valid, n_out_valid;
    bcr_pkg::t_out_item r_out, n_out;

    logic [BW-1:0] idx;
    logic [15:0]   interval, delay, cmp_limit;
    logic [31:0]   cmp_stamp;
    logic          cmp_gt, cmp_lt;
    logic          out_free, long_on, rep_fire, long_fire, emit;
    logic [2:0]    sel;

    assign idx       = r_btn[BW-1:0];
    assign interval  = r_rep_int[{r_btn, 4'b0000} +: 16];
    assign delay     = r_long_dly[{r_btn, 4'b0000} +: 16];
    assign cmp_stamp = (r_state == S_REP) ? r_rep_stamp[idx] : r_press_stamp[idx];
    assign cmp_limit = (r_state == S_REP) ? interval : delay;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign long_on   = r_long_mask[r_btn] && (delay != 16'd0);
    assign rep_fire  = r_click_mask[r_btn] && r_rep_armed[idx] && (interval != 16'd0) && cmp_gt;
    assign long_fire = long_on && r_long_armed[idx] && cmp_gt;

    bcr_time_cmp u_cmp (
        .i_now   (r_item.now_ms),
        .i_stamp (cmp_stamp),
        .i_limit (cmp_limit),
        .o_gt    (cmp_gt),
        .o_lt    (cmp_lt)
    );

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_btn         = r_btn;
        n_flags       = r_flags;
        n_press_stamp = r_press_stamp;
        n_rep_stamp   = r_rep_stamp;
        n_long_armed  = r_long_armed;
        n_rep_armed   = r_rep_armed;
        n_mode        = r_mode;
        emit          = 1'b0;
        sel           = 3'd0;
        n_out         = r_out;
        n_out.event_button = r_btn;
        n_out.any_held     = 1'b0;
        n_out.last         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_btn  = i_in_item.button;
                    if (i_in_item.action == bcr_pkg::ACT_TICK) begin
                        n_btn   = 2'd0;
                        n_state = S_REP;
                    end else if ({1'b0, i_in_item.button} >= BTN_LIM) begin
                        n_state = S_IDLE;
                    end else if (i_in_item.levels[i_in_item.button]) begin
                        n_state = S_PRESS;
                    end else begin
                        n_state = S_REL_CMP;
                    end
                end
            end
            S_PRESS: begin
                if (!r_rd_mask[r_btn] || out_free) begin
                    n_press_stamp[idx] = r_item.now_ms;
                    n_rep_stamp[idx]   = r_item.now_ms;
                    n_long_armed[idx]  = 1'b1;
                    n_rep_armed[idx]   = 1'b1;
                    n_mode[idx]        = bcr_pkg::MODE_PRESSED;
                    emit               = r_rd_mask[r_btn];
                    n_out.event_kind   = bcr_pkg::EV_RAW_DOWN;
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_REL_CMP: begin
                n_flags[F_CLICK] = r_click_mask[r_btn] &&
                                   (!long_on || (r_long_armed[idx] && cmp_lt));
                n_flags[F_LREL]  = r_lrel_mask[r_btn] && (r_mode[idx] == bcr_pkg::MODE_LONG);
                n_flags[F_RAWUP] = r_ru_mask[r_btn];
                n_press_stamp[idx] = 32'd0;
                n_rep_stamp[idx]   = 32'd0;
                n_long_armed[idx]  = 1'b0;
                n_rep_armed[idx]   = 1'b0;
                n_mode[idx]        = bcr_pkg::MODE_RELEASED;
                n_state            = S_REL_EMIT;
            end
            S_REL_EMIT: begin
                if (r_flags == 3'd0) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    if (r_flags[F_CLICK]) begin
                        sel              = 3'b001;
                        n_out.event_kind = bcr_pkg::EV_CLICK;
                    end else if (r_flags[F_LREL]) begin
                        sel              = 3'b010;
                        n_out.event_kind = bcr_pkg::EV_LONG_RELEASE;
                    end else begin
                        sel              = 3'b100;
                        n_out.event_kind = bcr_pkg::EV_RAW_UP;
                    end
                    emit       = 1'b1;
                    n_flags    = r_flags & ~sel;
                    n_out.last = (n_flags == 3'd0);
                    if (n_flags == 3'd0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REP: begin
                if (!r_item.levels[r_btn]) begin
                    if (r_btn == LAST_BTN) begin
                        n_state = S_DONE;
                    end else begin
                        n_btn = r_btn + 2'd1;
                    end
                end else if (!rep_fire) begin
                    n_state = S_LONG;
                end else if (out_free) begin
                    emit             = 1'b1;
                    n_out.event_kind = bcr_pkg::EV_CLICK;
                    n_mode[idx]      = bcr_pkg::MODE_REPEATING;
                    n_rep_stamp[idx] = r_item.now_ms;
                    n_state          = S_LONG;
                end
            end
            S_LONG: begin
                if (!long_fire || out_free) begin
                    if (long_fire) begin
                        emit               = 1'b1;
                        n_out.event_kind   = bcr_pkg::EV_LONG;
                        n_mode[idx]        = bcr_pkg::MODE_LONG;
                        n_long_armed[idx]  = 1'b0;
                        n_rep_armed[idx]   = 1'b0;
                        n_press_stamp[idx] = 32'd0;
                        n_rep_stamp[idx]   = 32'd0;
                    end
                    if (r_btn == LAST_BTN) begin
                        n_state = S_DONE;
                    end else begin
                        n_btn   = r_btn + 2'd1;
                        n_state = S_REP;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.event_kind   = bcr_pkg::EV_TICK_DONE;
                    n_out.event_button = 2'd0;
                    n_out.any_held     = |(r_item.levels & LVL_MASK);
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
            n_out       = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_flags      <= 3'd0;
            r_btn        <= 2'd0;
            r_rd_mask    <= 4'd0;
            r_ru_mask    <= 4'd0;
            r_click_mask <= 4'd0;
            r_long_mask  <= 4'd0;
            r_lrel_mask  <= 4'd0;
            r_rep_int    <= 64'd0;
            r_long_dly   <= 64'd0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_press_stamp[b] <= 32'd0;
                r_rep_stamp[b]   <= 32'd0;
                r_long_armed[b]  <= 1'b0;
                r_rep_armed[b]   <= 1'b0;
                r_mode[b]        <= bcr_pkg::MODE_RELEASED;
            end
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_flags       <= n_flags;
            r_btn         <= n_btn;
            r_press_stamp <= n_press_stamp;
            r_rep_stamp   <= n_rep_stamp;
            r_long_armed  <= n_long_armed;
            r_rep_armed   <= n_rep_armed;
            r_mode        <= n_mode;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bcr_pkg::CFG_RAW_DOWN_MASK:     r_rd_mask    <= i_cfg_data[3:0];
                    bcr_pkg::CFG_RAW_UP_MASK:       r_ru_mask    <= i_cfg_data[3:0];
                    bcr_pkg::CFG_CLICK_MASK:        r_click_mask <= i_cfg_data[3:0];
                    bcr_pkg::CFG_LONG_MASK:         r_long_mask  <= i_cfg_data[3:0];
                    bcr_pkg::CFG_LONG_RELEASE_MASK: r_lrel_mask  <= i_cfg_data[3:0];
                    bcr_pkg::CFG_REPEAT_INTERVALS:  r_rep_int    <= i_cfg_data;
                    bcr_pkg::CFG_LONG_DELAYS:       r_long_dly   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The summary and a raw-down result always close their transaction.
    a_tick_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_kind == bcr_pkg::EV_TICK_DONE) |-> o_out_item.last)
        else $error("tick summary not marked last");

    a_raw_down_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_kind == bcr_pkg::EV_RAW_DOWN) |-> o_out_item.last)
        else $error("raw down not marked last");

    a_tick_btn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REP || r_state == S_LONG) |-> ({1'b0, r_btn} < BTN_LIM))
        else $error("tick walk beyond button count");

    a_out_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.event_kind <= bcr_pkg::EV_TICK_DONE))
        else $error("invalid event kind");

    a_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && r_state != S_IDLE) |-> $past(r_state != S_IDLE))
        else $error("result produced without a transaction in progress");

endmodule

>>> tb/button_click_recognizer_unit_tb.sv
// Self-checking testbench for the button click recognizer with a built-in event predictor.
`timescale 1ns / 100ps

module button_click_recognizer_unit_tb;

    localparam int BTN_TOTAL = 4;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int RANDOM_PHASES = 6;

    typedef struct {
        bcr_pkg::t_in_item  item;
        bit                 scripted;
        int                 n_scripted;
        bcr_pkg::t_out_item scripted_ev;
    } t_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    bcr_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    bcr_pkg::t_out_item out_item;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = bcr_pkg::CFG_RAW_DOWN_MASK;
    logic [63:0]        cfg_data = '0;

    logic [3:0]  raw_down_en = '0;
    logic [3:0]  raw_up_en = '0;
    logic [3:0]  click_en = '0;
    logic [3:0]  long_en = '0;
    logic [3:0]  long_rel_en = '0;
    logic [63:0] repeat_ms = '0;
    logic [63:0] long_ms = '0;

    logic [31:0] press_ts [BTN_TOTAL] = '{default: '0};
    logic [31:0] repeat_ts [BTN_TOTAL] = '{default: '0};
    logic        long_arm [BTN_TOTAL] = '{default: 1'b0};
    logic        repeat_arm [BTN_TOTAL] = '{default: 1'b0};
    logic [1:0]  btn_mode [BTN_TOTAL] = '{default: bcr_pkg::MODE_RELEASED};

    bcr_pkg::t_out_item fresh_events[$];
    bcr_pkg::t_out_item pending_events[$];
    t_row               stim_table[$];

    logic [3:0]  held_now = '0;
    logic [31:0] clock_ms = '0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int          mismatches = 0;

    button_click_recognizer_unit #(
        .BUTTON_COUNT(BTN_TOTAL)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item(out_item),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("button_click_recognizer_unit_tb: done, errors");
        $finish;
    end

    function automatic void note(logic [2:0] kind, int unsigned b, logic any);
        bcr_pkg::t_out_item ev;
        ev.event_kind = kind;
        ev.event_button = 2'(b);
        ev.any_held = any;
        ev.last = 1'b0;
        fresh_events.push_back(ev);
    endfunction

    function automatic void recognize(input bcr_pkg::t_in_item it);
        int unsigned        b;
        logic [31:0]        interval;
        logic [31:0]        delay;
        logic [31:0]        held;
        logic               long_on;
        logic               any;
        bcr_pkg::t_out_item tail;
        fresh_events.delete();
        if (it.action == bcr_pkg::ACT_EDGE) begin
            b = it.button;
            if (b < BTN_TOTAL) begin
                if (it.levels[b]) begin
                    press_ts[b] = it.now_ms;
                    repeat_ts[b] = it.now_ms;
                    long_arm[b] = 1'b1;
                    repeat_arm[b] = 1'b1;
                    btn_mode[b] = bcr_pkg::MODE_PRESSED;
                    if (raw_down_en[b]) note(bcr_pkg::EV_RAW_DOWN, b, 1'b0);
                end else begin
                    delay = {16'd0, long_ms[16*b +: 16]};
                    held = it.now_ms - press_ts[b];
                    long_on = long_en[b] && (delay != 0);
                    if (click_en[b] && (!long_on || (long_arm[b] && held < delay)))
                        note(bcr_pkg::EV_CLICK, b, 1'b0);
                    if (long_rel_en[b] && btn_mode[b] == bcr_pkg::MODE_LONG)
                        note(bcr_pkg::EV_LONG_RELEASE, b, 1'b0);
                    if (raw_up_en[b]) note(bcr_pkg::EV_RAW_UP, b, 1'b0);
                    press_ts[b] = '0;
                    repeat_ts[b] = '0;
                    long_arm[b] = 1'b0;
                    repeat_arm[b] = 1'b0;
                    btn_mode[b] = bcr_pkg::MODE_RELEASED;
                end
            end
        end else begin
            any = 1'b0;
            for (int k = 0; k < BTN_TOTAL; k++) begin
                interval = {16'd0, repeat_ms[16*k +: 16]};
                delay = {16'd0, long_ms[16*k +: 16]};
                if (it.levels[k]) begin
                    any = 1'b1;
                    if (click_en[k] && repeat_arm[k] && interval != 0 &&
                        (it.now_ms - repeat_ts[k]) > interval) begin
                        btn_mode[k] = bcr_pkg::MODE_REPEATING;
                        note(bcr_pkg::EV_CLICK, k, 1'b0);
                        repeat_ts[k] = it.now_ms;
                    end
                    if (long_en[k] && long_arm[k] && delay != 0 &&
                        (it.now_ms - press_ts[k]) > delay) begin
                        btn_mode[k] = bcr_pkg::MODE_LONG;
                        note(bcr_pkg::EV_LONG, k, 1'b0);
                        long_arm[k] = 1'b0;
                        repeat_arm[k] = 1'b0;
                        press_ts[k] = '0;
                        repeat_ts[k] = '0;
                    end
                end
            end
            note(bcr_pkg::EV_TICK_DONE, 0, any);
        end
        if (fresh_events.size() != 0) begin
            tail = fresh_events.pop_back();
            tail.last = 1'b1;
            fresh_events.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        bcr_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result: event_kind %0d, event_button %0d",
                       out_item.event_kind, out_item.event_button);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.event_kind, out_item.event_kind);
                check_field("event_button", want.event_button, out_item.event_button);
                check_field("any_held", want.any_held, out_item.any_held);
                check_field("last", want.last, out_item.last);
            end
        end
    end

    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            bcr_pkg::CFG_RAW_DOWN_MASK:     raw_down_en = val[3:0];
            bcr_pkg::CFG_RAW_UP_MASK:       raw_up_en = val[3:0];
            bcr_pkg::CFG_CLICK_MASK:        click_en = val[3:0];
            bcr_pkg::CFG_LONG_MASK:         long_en = val[3:0];
            bcr_pkg::CFG_LONG_RELEASE_MASK: long_rel_en = val[3:0];
            bcr_pkg::CFG_REPEAT_INTERVALS:  repeat_ms = val;
            bcr_pkg::CFG_LONG_DELAYS:       long_ms = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_regs(input logic [3:0] rd, input logic [3:0] ru, input logic [3:0] ck,
                              input logic [3:0] lg, input logic [3:0] lr,
                              input logic [63:0] rep, input logic [63:0] dly);
        cfg_write(bcr_pkg::CFG_RAW_DOWN_MASK, {60'd0, rd});
        cfg_write(bcr_pkg::CFG_RAW_UP_MASK, {60'd0, ru});
        cfg_write(bcr_pkg::CFG_CLICK_MASK, {60'd0, ck});
        cfg_write(bcr_pkg::CFG_LONG_MASK, {60'd0, lg});
        cfg_write(bcr_pkg::CFG_LONG_RELEASE_MASK, {60'd0, lr});
        cfg_write(bcr_pkg::CFG_REPEAT_INTERVALS, rep);
        cfg_write(bcr_pkg::CFG_LONG_DELAYS, dly);
    endtask

    task automatic offer(input bcr_pkg::t_in_item it, input bit scripted, input int n_scripted,
                         input bcr_pkg::t_out_item scripted_ev);
        if (!calm && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        recognize(it);
        if (scripted) begin
            if (n_scripted > 0) pending_events.push_back(scripted_ev);
        end else begin
            foreach (fresh_events[k]) pending_events.push_back(fresh_events[k]);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_row(input logic act, input logic [1:0] btn, input logic [3:0] lv,
                           input logic [31:0] now, input bit scripted = 1'b0,
                           input int n_scripted = 0,
                           input logic [2:0] kind = bcr_pkg::EV_TICK_DONE,
                           input logic [1:0] ev_btn = 2'd0, input logic any = 1'b0);
        t_row r;
        r.item.action = act;
        r.item.button = btn;
        r.item.levels = lv;
        r.item.now_ms = now;
        r.scripted = scripted;
        r.n_scripted = n_scripted;
        r.scripted_ev.event_kind = kind;
        r.scripted_ev.event_button = ev_btn;
        r.scripted_ev.any_held = any;
        r.scripted_ev.last = 1'b1;
        stim_table.push_back(r);
    endtask

    task automatic walk_table();
        foreach (stim_table[r])
            offer(stim_table[r].item, stim_table[r].scripted, stim_table[r].n_scripted,
                  stim_table[r].scripted_ev);
        stim_table.delete();
        drain();
    endtask

    function automatic logic [63:0] pick_times(bit is_delay);
        logic [63:0] v;
        int unsigned r;
        for (int k = 0; k < BTN_TOTAL; k++) begin
            r = $urandom_range(99);
            if (r < 15) v[16*k +: 16] = 16'd0;
            else if (r < 25) v[16*k +: 16] = 16'hFFFF;
            else if (is_delay) v[16*k +: 16] = 16'($urandom_range(20, 300));
            else v[16*k +: 16] = 16'($urandom_range(1, 80));
        end
        return v;
    endfunction

    function automatic logic [3:0] pick_mask();
        return ($urandom_range(99) < 25) ? 4'hF : 4'($urandom);
    endfunction

    function automatic logic [31:0] advance_ms();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 32'($urandom_range(0, 60));
        if (r < 90) return 32'($urandom_range(0, 400));
        if (r < 97) return 32'($urandom_range(32'h10000, 32'h1FFFF));
        return 32'($urandom);
    endfunction

    function automatic bcr_pkg::t_in_item next_press_or_tick();
        bcr_pkg::t_in_item it;
        int unsigned r;
        int unsigned b;
        r = $urandom_range(99);
        clock_ms = clock_ms + advance_ms();
        it.now_ms = clock_ms;
        it.button = 2'($urandom);
        if (r < 45) begin
            it.action = bcr_pkg::ACT_TICK;
            it.levels = held_now;
        end else if (r < 88) begin
            b = $urandom_range(BTN_TOTAL - 1);
            held_now[b] = ~held_now[b];
            it.action = bcr_pkg::ACT_EDGE;
            it.button = 2'(b);
            it.levels = held_now;
        end else if (r < 94) begin
            it.action = bcr_pkg::ACT_EDGE;
            it.levels = 4'($urandom);
            held_now = it.levels;
        end else begin
            it.action = bcr_pkg::ACT_TICK;
            it.levels = 4'($urandom);
        end
        return it;
    endfunction

    task automatic random_phase(input int n_items, input bit pause_mid);
        bcr_pkg::t_in_item it;
        for (int k = 0; k < n_items; k++) begin
            if (pause_mid && k == n_items / 2) begin
                in_valid <= 1'b0;
                do @(negedge clk); while (pending_events.size() != 0);
            end
            it = next_press_or_tick();
            offer(it, 1'b0, 0, '0);
        end
        drain();
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apply_regs(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 64'd0, 64'd0);
        add_row(bcr_pkg::ACT_EDGE, 2'd0, 4'b0001, 32'd0, 1'b1, 0);
        add_row(bcr_pkg::ACT_TICK, 2'd3, 4'b1111, 32'hFFFF_FFFF, 1'b1, 1,
                bcr_pkg::EV_TICK_DONE, 2'd0, 1'b1);
        add_row(bcr_pkg::ACT_TICK, 2'd0, 4'b0000, 32'd5, 1'b1, 1,
                bcr_pkg::EV_TICK_DONE, 2'd0, 1'b0);
        add_row(bcr_pkg::ACT_EDGE, 2'd0, 4'b0000, 32'd9, 1'b1, 0);
        walk_table();

        apply_regs(4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
                   {16'hFFFF, 16'd20, 16'd0, 16'd10}, {16'hFFFF, 16'd0, 16'd40, 16'd50});
        add_row(bcr_pkg::ACT_EDGE, 2'd0, 4'b0001, 32'd100, 1'b1, 1, bcr_pkg::EV_RAW_DOWN, 2'd0);
        add_row(bcr_pkg::ACT_TICK, 2'd0, 4'b0001, 32'd110);
        add_row(bcr_pkg::ACT_TICK, 2'd0, 4'b0001, 32'd111);
        add_row(bcr_pkg::ACT_TICK, 2'd0, 4'b0001, 32'd151);
        add_row(bcr_pkg::ACT_EDGE, 2'd0, 4'b0000, 32'd160);
        add_row(bcr_pkg::ACT_EDGE, 2'd1, 4'b0010, 32'hFFFF_FFF0, 1'b1, 1,
                bcr_pkg::EV_RAW_DOWN, 2'd1);
        add_row(bcr_pkg::ACT_EDGE, 2'd1, 4'b0000, 32'h0000_0010);
        add_row(bcr_pkg::ACT_EDGE, 2'd2, 4'b0000, 32'd20);
        add_row(bcr_pkg::ACT_EDGE, 2'd1, 4'b0000, 32'd25);
        add_row(bcr_pkg::ACT_EDGE, 2'd2, 4'b0100, 32'd1000);
        add_row(bcr_pkg::ACT_TICK, 2'd1, 4'b0100, 32'd1021);
        add_row(bcr_pkg::ACT_EDGE, 2'd2, 4'b0000, 32'd5000);
        add_row(bcr_pkg::ACT_EDGE, 2'd3, 4'b1000, 32'd0, 1'b1, 1, bcr_pkg::EV_RAW_DOWN, 2'd3);
        add_row(bcr_pkg::ACT_EDGE, 2'd0, 4'b1001, 32'd0, 1'b1, 1, bcr_pkg::EV_RAW_DOWN, 2'd0);
        add_row(bcr_pkg::ACT_EDGE, 2'd1, 4'b1011, 32'd0, 1'b1, 1, bcr_pkg::EV_RAW_DOWN, 2'd1);
        add_row(bcr_pkg::ACT_EDGE, 2'd2, 4'b1111, 32'd0, 1'b1, 1, bcr_pkg::EV_RAW_DOWN, 2'd2);
        add_row(bcr_pkg::ACT_TICK, 2'd2, 4'b1111, 32'h0001_0000);
        add_row(bcr_pkg::ACT_TICK, 2'd3, 4'b1111, 32'hFFFF_FFFF);
        add_row(bcr_pkg::ACT_EDGE, 2'd3, 4'b0111, 32'hFFFF_FFFF);
        add_row(bcr_pkg::ACT_EDGE, 2'd2, 4'b0011, 32'hFFFF_FFFF);
        add_row(bcr_pkg::ACT_EDGE, 2'd1, 4'b0001, 32'hFFFF_FFFF);
        add_row(bcr_pkg::ACT_EDGE, 2'd0, 4'b0000, 32'hFFFF_FFFF);
        add_row(bcr_pkg::ACT_TICK, 2'd0, 4'b0000, 32'd0, 1'b1, 1,
                bcr_pkg::EV_TICK_DONE, 2'd0, 1'b0);
        walk_table();

        clock_ms = $urandom;
        held_now = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                apply_regs(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, '1, '1);
            else if (ph == 1)
                apply_regs(4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
                           {4{16'd1}}, {4{16'd1}});
            else
                apply_regs(pick_mask(), pick_mask(), pick_mask(), pick_mask(), pick_mask(),
                           pick_times(1'b0), pick_times(1'b1));
            calm = (ph == 3);
            if (ph == 2) hold_req = 1'b1;
            random_phase(ITEMS_PER_PHASE, ph == 4);
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("button_click_recognizer_unit_tb: done, clean");
        else
            $display("button_click_recognizer_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> button_click_recognizer_unit.f
hw/rtl/bcr_pkg.sv
hw/rtl/bcr_time_cmp.sv
hw/rtl/button_click_recognizer_unit.sv
tb/button_click_recognizer_unit_tb.sv
